// File: hdl/smnd_pkg.sv
`default_nettype none
package smnd_pkg;

   localparam int unsigned CHUNK_BINS_DEF     = 16;
   localparam int unsigned DISPLAY_POINTS_DEF = 8192;

   // ln2 * 2^32, rounded to nearest.
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
   localparam logic [3:0]  MAX_SHIFT = 4'd14;

   localparam int unsigned CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMBINE_LOG2 = 2'd0,
      CSR_FIXED_NORM   = 2'd1,
      CSR_DC_FIRST     = 2'd2
   } csr_index_type;

   // Request to the normalizer.
   typedef struct packed {
      logic        start;
      logic [31:0] power;
      logic [31:0] median;
      logic [31:0] fixed_norm;
   } norm_req_type;

   // Answer from the normalizer.
   typedef struct packed {
      logic        done;
      logic        busy;
      logic [31:0] value;
   } norm_rsp_type;

endpackage
`default_nettype wire

// File: hdl/smnd_ifs.sv
`default_nettype none
interface smnd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] amp_re;
   logic signed [15:0] amp_im;
   modport source (output valid, amp_re, amp_im, input ready);
   modport sink   (input valid, amp_re, amp_im, output ready);
endinterface

interface smnd_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] point_index;
   logic [31:0] point_power;
   logic [31:0] view_peak;
   logic        run_last;
   logic        view_done;
   modport source (output valid, point_index, point_power, view_peak, run_last, view_done,
                   input ready);
   modport sink   (input valid, point_index, point_power, view_peak, run_last, view_done,
                   output ready);
endinterface

interface smnd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/smnd_cell.sv
`default_nettype none
// One cell of the chunk chain: an arrival-order shift slot plus one slot of
// a sorted (ascending) insertion chain. Empty sorted slots act as +infinity.
module smnd_cell
   import smnd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        shift,
   input  wire logic        insert,
   input  wire logic        clear,
   input  wire logic [31:0] x,
   input  wire logic [31:0] arr_next,
   input  wire logic        left_lt,
   input  wire logic [31:0] left_val,
   input  wire logic        left_vld,
   output logic      [31:0] arr,
   output logic      [31:0] val,
   output logic             vld,
   output logic             lt
);
   logic [31:0] arr_ff;
   logic [31:0] val_ff;
   logic        vld_ff;

   assign lt  = !vld_ff || (x < val_ff);
   assign arr = arr_ff;
   assign val = val_ff;
   assign vld = vld_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         arr_ff <= arr_next;
      end
      if (reset || clear) begin
         vld_ff <= 1'b0;
      end else if (insert) begin
         if (left_lt) begin
            val_ff <= left_val;
            vld_ff <= left_vld;
         end else if (lt) begin
            val_ff <= x;
            vld_ff <= 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

// File: hdl/smnd_norm.sv
`default_nettype none
// Normalizes one power: multiply, then either saturate (constant mode) or
// divide by median*2^16 with a restoring divider, one quotient bit a cycle.
module smnd_norm
   import smnd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire norm_req_type  req,
   output norm_rsp_type       rsp
);
   typedef enum logic [2:0] {N_IDLE, N_MUL, N_CHK, N_DIV} nstate_type;

   nstate_type  state_ff;
   logic [31:0] p_ff;
   logic [31:0] med_ff;
   logic [31:0] fix_ff;
   logic [63:0] prod_ff;
   logic [47:0] rem_ff;
   logic [31:0] q_ff;
   logic [4:0]  cnt_ff;
   logic        done_ff;
   logic [31:0] res_ff;

   logic [47:0] divisor;
   logic [48:0] trial;
   logic        take;

   assign divisor = {med_ff, 16'b0};
   assign trial   = {rem_ff, q_ff[31]};
   assign take    = trial >= {1'b0, divisor};

   assign rsp.done  = done_ff;
   assign rsp.busy  = (state_ff != N_IDLE);
   assign rsp.value = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            N_IDLE: begin
               if (req.start) begin
                  p_ff     <= req.power;
                  med_ff   <= req.median;
                  fix_ff   <= req.fixed_norm;
                  state_ff <= N_MUL;
               end
            end
            N_MUL: begin
               prod_ff  <= 64'(p_ff) * 64'((fix_ff != 32'd0) ? fix_ff : LN2_Q32);
               state_ff <= N_CHK;
            end
            N_CHK: begin
               if (fix_ff != 32'd0) begin
                  res_ff   <= (prod_ff[63:32] != 32'd0) ? SAT32 : prod_ff[31:0];
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else if (med_ff == 32'd0) begin
                  res_ff   <= (p_ff == 32'd0) ? 32'd0 : SAT32;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else if (48'(prod_ff[63:32]) >= divisor) begin
                  res_ff   <= SAT32;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else begin
                  rem_ff   <= 48'(prod_ff[63:32]);
                  q_ff     <= prod_ff[31:0];
                  cnt_ff   <= 5'd0;
                  state_ff <= N_DIV;
               end
            end
            N_DIV: begin
               rem_ff <= take ? 48'(trial - {1'b0, divisor}) : trial[47:0];
               q_ff   <= {q_ff[30:0], take};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  res_ff   <= {q_ff[30:0], take};
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: hdl/spectrum_median_normalize_decimate.sv
`default_nettype none
// Median-normalized power spectrum with max decimation. Each request
// transaction carries one FFT bin (amp_re, amp_im); the block forms its power
// and pushes it into a chain of CHUNK_BINS cells that keeps both the arrival
// order and a sorted copy. A bin that does not complete a chunk passes through
// the accept and insert states before the input is ready for the next bin. When
// a chunk completes, the lower median is read from the sorted chain and the
// powers are shifted out one by one through the normalizer. In median mode each
// bin goes through launch, multiply, range check, 32 divider steps that each
// yield one quotient bit, result collection and the decimation step; constant
// mode, an early saturation and a zero median skip the divider steps. A
// stalled response channel holds the drain in the decimation step. Each
// completed display point is delivered as one response transaction carrying
// the point index, its power, the running view peak, a flag on the last point
// caused by the request, and a view-complete flag. No new request is taken
// while a chunk is being normalized. Configuration writes are always accepted.
module spectrum_median_normalize_decimate
   import smnd_pkg::*;
#(
   parameter int unsigned CHUNK_BINS     = CHUNK_BINS_DEF,
   parameter int unsigned DISPLAY_POINTS = DISPLAY_POINTS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   smnd_req_if.sink   req_ch,
   smnd_rsp_if.source rsp_ch,
   smnd_csr_if.sink   csr_ch
);
   localparam int unsigned CW  = $clog2(CHUNK_BINS);
   localparam int unsigned PCW = $clog2(DISPLAY_POINTS);
   localparam int unsigned MED = (CHUNK_BINS - 1) / 2;
   localparam logic [CW-1:0]  LAST_BIN   = CW'(CHUNK_BINS - 1);
   localparam logic [PCW-1:0] LAST_POINT = PCW'(DISPLAY_POINTS - 1);

   typedef enum logic [2:0] {S_IDLE, S_INS, S_MED, S_POP, S_WAIT, S_DEC} state_type;

   // Configuration registers.
   logic [3:0]  combine_ff;
   logic [31:0] fixed_ff;
   logic        dc_first_ff;

   // Control and datapath state.
   state_type      state_ff;
   logic [31:0]    p_ff;
   logic           seen_ff;
   logic [CW-1:0]  fill_ff;
   logic [CW-1:0]  idx_ff;
   logic [31:0]    med_ff;
   logic [31:0]    v_ff;
   logic [31:0]    gmax_ff;
   logic [13:0]    gfill_ff;
   logic [PCW-1:0] pcount_ff;
   logic [31:0]    peak_ff;

   // Response register.
   logic           rsp_valid_ff;
   logic [PCW-1:0] pidx_ff;
   logic [31:0]    ppow_ff;
   logic [31:0]    vpeak_ff;
   logic           last_ff;
   logic           vdone_ff;

   // Cell chain wiring.
   logic [31:0] arr_x [CHUNK_BINS+1];
   logic [31:0] val_x [CHUNK_BINS+1];
   logic        vld_x [CHUNK_BINS+1];
   logic        lt_x  [CHUNK_BINS+1];
   logic [31:0] cell_in;
   logic        do_shift;
   logic        do_insert;
   logic        do_clear;

   norm_req_type nreq;
   norm_rsp_type nrsp;

   // Power of the incoming bin: both squares are non-negative and the sum
   // never exceeds 2^31.
   logic signed [31:0] sq_re;
   logic signed [31:0] sq_im;
   logic [31:0]        p_new;
   logic [31:0]        p_dc;

   assign sq_re = req_ch.amp_re * req_ch.amp_re;
   assign sq_im = req_ch.amp_im * req_ch.amp_im;
   assign p_new = 32'(sq_re) + 32'(sq_im);
   assign p_dc  = (!seen_ff && dc_first_ff) ? 32'd1 : p_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   // Decimator arithmetic for the value that just left the normalizer.
   logic [3:0]    shift_amt;
   logic [14:0]   gsize;
   logic [14:0]   gfill_nx;
   logic [31:0]   vmax;
   logic [31:0]   peak_nx;
   logic          emit;
   logic          out_busy;
   logic          load_rsp;
   logic [CW-1:0] remaining;
   logic          view_end;

   assign shift_amt = (combine_ff > MAX_SHIFT) ? MAX_SHIFT : combine_ff;
   assign gsize     = 15'd1 << shift_amt;
   assign gfill_nx  = {1'b0, gfill_ff} + 15'd1;
   assign vmax      = (v_ff > gmax_ff) ? v_ff : gmax_ff;
   assign peak_nx   = (vmax > peak_ff) ? vmax : peak_ff;
   assign emit      = (gfill_nx >= gsize);
   assign out_busy  = rsp_valid_ff && !rsp_ch.ready;
   assign load_rsp  = (state_ff == S_DEC) && emit && !out_busy;
   assign remaining = LAST_BIN - idx_ff;
   assign view_end  = (pcount_ff == LAST_POINT);

   // The cells shift on every insert (new bin enters at the far end) and on
   // every pop (oldest bin leaves at cell zero).
   assign do_insert = (state_ff == S_INS);
   assign do_shift  = do_insert || (state_ff == S_POP);
   assign do_clear  = (state_ff == S_MED);
   assign cell_in   = do_insert ? p_dc : 32'd0;

   assign arr_x[CHUNK_BINS] = cell_in;
   assign val_x[0] = 32'd0;
   assign vld_x[0] = 1'b0;
   assign lt_x[0]  = 1'b0;

   for (genvar i = 0; i < CHUNK_BINS; i++) begin : g_cell
      smnd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (do_shift),
         .insert   (do_insert),
         .clear    (do_clear),
         .x        (p_dc),
         .arr_next (arr_x[i+1]),
         .left_lt  (lt_x[i]),
         .left_val (val_x[i]),
         .left_vld (vld_x[i]),
         .arr      (arr_x[i]),
         .val      (val_x[i+1]),
         .vld      (vld_x[i+1]),
         .lt       (lt_x[i+1])
      );
   end

   assign nreq.start      = (state_ff == S_POP);
   assign nreq.power      = arr_x[0];
   assign nreq.median     = med_ff;
   assign nreq.fixed_norm = fixed_ff;

   smnd_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   logic [31:0] pidx_wide;
   assign pidx_wide = 32'(pidx_ff);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.point_index = pidx_wide[12:0];
   assign rsp_ch.point_power = ppow_ff;
   assign rsp_ch.view_peak   = vpeak_ff;
   assign rsp_ch.run_last    = last_ff;
   assign rsp_ch.view_done   = vdone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         combine_ff   <= 4'd4;
         fixed_ff     <= 32'd0;
         dc_first_ff  <= 1'b1;
         state_ff     <= S_IDLE;
         seen_ff      <= 1'b0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         gmax_ff      <= 32'd0;
         gfill_ff     <= 14'd0;
         pcount_ff    <= '0;
         peak_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_index_type'(csr_ch.index))
               CSR_COMBINE_LOG2: combine_ff  <= csr_ch.data[3:0];
               CSR_FIXED_NORM:   fixed_ff    <= csr_ch.data;
               CSR_DC_FIRST:     dc_first_ff <= csr_ch.data[0];
               default: ;
            endcase
         end
         // A new point takes the response register; otherwise it empties
         // once the receiver has taken its transaction.
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  p_ff     <= p_new;
                  state_ff <= S_INS;
               end
            end
            S_INS: begin
               seen_ff <= 1'b1;
               if (fill_ff == LAST_BIN) begin
                  fill_ff  <= '0;
                  state_ff <= S_MED;
               end else begin
                  fill_ff  <= fill_ff + CW'(1);
                  state_ff <= S_IDLE;
               end
            end
            S_MED: begin
               med_ff   <= val_x[MED+1];
               idx_ff   <= '0;
               state_ff <= S_POP;
            end
            S_POP: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (nrsp.done) begin
                  v_ff     <= nrsp.value;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               if (!(emit && out_busy)) begin
                  if (emit) begin
                     pidx_ff      <= pcount_ff;
                     ppow_ff      <= vmax;
                     vpeak_ff     <= peak_nx;
                     last_ff      <= (15'(remaining) < gsize);
                     vdone_ff     <= view_end;
                     gmax_ff      <= 32'd0;
                     gfill_ff     <= 14'd0;
                     if (view_end) begin
                        pcount_ff <= '0;
                        peak_ff   <= 32'd0;
                     end else begin
                        pcount_ff <= pcount_ff + PCW'(1);
                        peak_ff   <= peak_nx;
                     end
                  end else begin
                     gmax_ff  <= vmax;
                     gfill_ff <= gfill_nx[13:0];
                  end
                  if (idx_ff == LAST_BIN) begin
                     idx_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + CW'(1);
                     state_ff <= S_POP;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // A request is only taken when the normalizer has nothing in flight.
   a_ready_norm_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !nrsp.busy)
      else $error("request accepted while normalizer busy");

   // A new response is only ever loaded from the decimation step.
   a_rsp_from_dec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DEC))
      else $error("response loaded outside decimation");

   // The sorted chain is emptied before the chunk is drained.
   a_sorted_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> !vld_x[1])
      else $error("sorted chain not cleared before drain");

   // The normalizer answers only when the control is waiting for it.
   a_norm_done_wait: assert property (@(posedge clock) disable iff (reset)
      nrsp.done |-> (state_ff == S_WAIT))
      else $error("normalizer result not expected");
`endif
endmodule
`default_nettype wire

// File: sim/smnd_spectrum_checker.sv
`default_nettype none
// Watches the request, response and register channels of the spectrum block,
// predicts every display point and compares it field by field.
module smnd_spectrum_checker
   import smnd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   smnd_req_if      req_mon,
   smnd_rsp_if      rsp_mon,
   smnd_csr_if      csr_mon,
   output int       error_count,
   output int       points_pending,
   output int       points_checked
);

   typedef struct packed {
      logic [12:0] point_index;
      logic [31:0] point_power;
      logic [31:0] view_peak;
      logic        run_last;
      logic        view_done;
   } display_point_type;

   display_point_type point_queue[$];

   logic [3:0]  combine_log2_q;
   logic [31:0] fixed_norm_q;
   logic        dc_first_q;
   logic [31:0] chunk_power[CHUNK_BINS_DEF];
   int unsigned chunk_count;
   logic        first_bin_seen;
   logic [31:0] group_peak;
   int unsigned group_count;
   int unsigned point_number;
   logic [31:0] view_max;

   assign points_pending = point_queue.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [31:0] chunk_lower_median();
      logic [31:0] sorted[CHUNK_BINS_DEF];
      logic [31:0] v;
      int          j;
      for (int i = 0; i < CHUNK_BINS_DEF; i++) sorted[i] = chunk_power[i];
      for (int i = 1; i < CHUNK_BINS_DEF; i++) begin
         v = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > v) begin
            sorted[j+1] = sorted[j];
            j--;
         end
         sorted[j+1] = v;
      end
      return sorted[(CHUNK_BINS_DEF-1)/2];
   endfunction

   function automatic logic [31:0] scale_power(input logic [31:0] p, input logic [31:0] med);
      logic [63:0] r;
      if (fixed_norm_q != 0) begin
         r = 64'(p) * 64'(fixed_norm_q);
         return (r > 64'(SAT32)) ? SAT32 : r[31:0];
      end
      if (med == 0) return (p == 0) ? 32'd0 : SAT32;
      r = (64'(p) * 64'(LN2_Q32)) / (64'(med) << 16);
      return (r > 64'(SAT32)) ? SAT32 : r[31:0];
   endfunction

   task automatic accept_bin(input logic signed [15:0] re, input logic signed [15:0] im);
      logic signed [31:0] re_w;
      logic signed [31:0] im_w;
      logic [31:0]        p;
      logic [31:0]        med;
      logic [31:0]        v;
      int unsigned        group_size;
      int                 first_new;
      display_point_type  pt;
      re_w = re;
      im_w = im;
      p = 32'(re_w * re_w) + 32'(im_w * im_w);
      if (!first_bin_seen && dc_first_q) p = 32'd1;
      first_bin_seen = 1'b1;
      chunk_power[chunk_count] = p;
      chunk_count++;
      if (chunk_count < CHUNK_BINS_DEF) return;
      chunk_count = 0;
      med = chunk_lower_median();
      group_size = 1 << ((combine_log2_q > MAX_SHIFT) ? MAX_SHIFT : combine_log2_q);
      first_new = point_queue.size();
      for (int i = 0; i < CHUNK_BINS_DEF; i++) begin
         v = scale_power(chunk_power[i], med);
         if (v > group_peak) group_peak = v;
         group_count++;
         if (group_count >= group_size) begin
            if (group_peak > view_max) view_max = group_peak;
            pt.point_index = 13'(point_number);
            pt.point_power = group_peak;
            pt.view_peak   = view_max;
            pt.run_last    = 1'b0;
            pt.view_done   = (point_number >= DISPLAY_POINTS_DEF - 1);
            point_queue.push_back(pt);
            group_peak  = 0;
            group_count = 0;
            if (pt.view_done) begin
               point_number = 0;
               view_max     = 0;
            end else begin
               point_number++;
            end
         end
      end
      if (point_queue.size() > first_new) point_queue[$].run_last = 1'b1;
   endtask

   always @(posedge clock) begin
      display_point_type want;
      if (reset) begin
         combine_log2_q = 4'd4;
         fixed_norm_q   = 0;
         dc_first_q     = 1'b1;
         for (int i = 0; i < CHUNK_BINS_DEF; i++) chunk_power[i] = 0;
         chunk_count    = 0;
         first_bin_seen = 1'b0;
         group_peak     = 0;
         group_count    = 0;
         point_number   = 0;
         view_max       = 0;
         error_count    = 0;
         points_checked = 0;
         point_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (point_queue.size() == 0) begin
               report_mismatch("unexpected point", 32'(rsp_mon.point_index), 0);
            end else begin
               want = point_queue.pop_front();
               points_checked++;
               if (rsp_mon.point_index !== want.point_index)
                  report_mismatch("point_index", 32'(rsp_mon.point_index),
                                  32'(want.point_index));
               if (rsp_mon.point_power !== want.point_power)
                  report_mismatch("point_power", rsp_mon.point_power, want.point_power);
               if (rsp_mon.view_peak !== want.view_peak)
                  report_mismatch("view_peak", rsp_mon.view_peak, want.view_peak);
               if (rsp_mon.run_last !== want.run_last)
                  report_mismatch("run_last", 32'(rsp_mon.run_last), 32'(want.run_last));
               if (rsp_mon.view_done !== want.view_done)
                  report_mismatch("view_done", 32'(rsp_mon.view_done), 32'(want.view_done));
            end
         end
         if (req_mon.valid && req_mon.ready) accept_bin(req_mon.amp_re, req_mon.amp_im);
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_COMBINE_LOG2: combine_log2_q = csr_mon.data[3:0];
               CSR_FIXED_NORM:   fixed_norm_q   = csr_mon.data;
               CSR_DC_FIRST:     dc_first_q     = csr_mon.data[0];
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// File: sim/spectrum_median_normalize_decimate_tb.sv
`default_nettype none
// Top level of the testbench. It builds the channels, drives bins and register
// writes on the falling edge, applies back pressure to the response side and
// gives the verdict from the checker's error count.
module spectrum_median_normalize_decimate_tb;
   import smnd_pkg::*;

   logic clock;
   logic reset;
   int   error_count;
   int   points_pending;
   int   points_checked;
   int   bins_sent;
   int   phase_count;
   bit   hold_rsp;
   bit   rsp_free;

   smnd_req_if req_ch ();
   smnd_rsp_if rsp_ch ();
   smnd_csr_if csr_ch ();

   spectrum_median_normalize_decimate uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   smnd_spectrum_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .error_count    (error_count),
      .points_pending (points_pending),
      .points_checked (points_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A generous ceiling for the whole run, response stalls included.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   // The receiver stalls on its own pattern: mostly free, sometimes a random
   // busy run. When hold_rsp is set it holds off completely.
   initial begin
      int pattern_left;
      rsp_ch.ready = 1'b0;
      pattern_left = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            rsp_free     = !rsp_free;
            pattern_left = rsp_free ? $urandom_range(1, 30) : $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) rsp_free = 1'b1;
         end
         pattern_left--;
         rsp_ch.ready <= rsp_free && !hold_rsp;
      end
   end

   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // One bin transaction; valid stays high until the block accepts it.
   // The caller lowers valid when a gap follows.
   task automatic send_bin(input logic [15:0] re, input logic [15:0] im);
      req_ch.valid  <= 1'b1;
      req_ch.amp_re <= re;
      req_ch.amp_im <= im;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      bins_sent++;
   endtask

   task automatic gap_cycles(input int n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Random amplitude that touches every bit, with a bias toward small values
   // so that medians and constants land in interesting ranges.
   function automatic logic [15:0] random_amp();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 64)) - 32);
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($signed($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   // A chunk of bins sent in random bursts with random gaps between them.
   task automatic send_random_chunk();
      int burst;
      burst = 0;
      for (int i = 0; i < CHUNK_BINS_DEF; i++) begin
         if (burst == 0) begin
            gap_cycles($urandom_range(0, 4));
            burst = $urandom_range(1, 8);
         end
         burst--;
         send_bin(random_amp(), random_amp());
      end
      req_ch.valid <= 1'b0;
   endtask

   // Waits until every predicted point has arrived, then lets the block settle
   // for the length of one normalization pass before registers may change.
   task automatic drain_points();
      req_ch.valid <= 1'b0;
      while (points_pending != 0) @(negedge clock);
      repeat (CHUNK_BINS_DEF * 40) @(negedge clock);
      phase_count++;
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.amp_re = '0;
      req_ch.amp_im = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_COMBINE_LOG2;
      csr_ch.data   = '0;
      hold_rsp      = 1'b0;
      rsp_free      = 1'b1;
      bins_sent     = 0;
      phase_count   = 0;
      reset         = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the DC bin first (reset registers, median mode, groups of 16),
      // then field extremes and a zero bin.
      send_bin(16'h7FFF, 16'h7FFF);
      send_bin(16'h8000, 16'h8000);
      send_bin(16'h8000, 16'h7FFF);
      send_bin(16'h0000, 16'h0000);
      send_bin(16'hFFFF, 16'h0001);
      for (int i = 5; i < CHUNK_BINS_DEF; i++) send_bin(16'(i), 16'(-i));
      req_ch.valid <= 1'b0;
      drain_points();

      // Zero median with a few nonzero bins: those saturate, zeros stay zero.
      write_register(CSR_COMBINE_LOG2, 32'd0);
      for (int i = 0; i < CHUNK_BINS_DEF; i++)
         send_bin((i % 5 == 0) ? 16'h0003 : 16'h0000, 16'h0000);
      req_ch.valid <= 1'b0;
      drain_points();

      // Random phases sweep the registers through their extremes, including a
      // combine field above range and the largest constant factor.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_register(CSR_FIXED_NORM, 32'hFFFF_FFFF);
               write_register(CSR_COMBINE_LOG2, 32'd1);
            end
            1: begin
               write_register(CSR_FIXED_NORM, 32'h0000_0001);
               write_register(CSR_COMBINE_LOG2, 32'd15);
            end
            2: begin
               write_register(CSR_FIXED_NORM, 32'h0001_0000);
               write_register(CSR_COMBINE_LOG2, 32'd14);
            end
            3: begin
               write_register(CSR_FIXED_NORM, 32'd0);
               write_register(CSR_COMBINE_LOG2, 32'd2);
               write_register(CSR_DC_FIRST, 32'd0);
            end
            default: begin
               write_register(CSR_FIXED_NORM, 32'd0);
               write_register(CSR_COMBINE_LOG2, 32'd0);
               write_register(CSR_DC_FIRST, 32'd1);
            end
         endcase
         // In the zero-combine phase the receiver holds off for a long stretch
         // while bins keep coming, so the block fills up and stalls its input.
         if (ph == 4) begin
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (3000) @(negedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         send_random_chunk();
         if (ph == 4) send_random_chunk();
         drain_points();
      end

      $display("covered %0d bins and %0d display points over %0d register phases",
               bins_sent, points_checked, phase_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
